// ===== rtl/svo_pkg.sv =====
package svo_pkg;

   // fixed field widths
   localparam int OP_W     = 3;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 15;
   localparam int AMP_W    = 9;
   localparam int PHASE_W  = 10;
   localparam int OFFSET_W = 9;
   localparam int POS_W    = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // phase numerator (t*360 + (phase+720)*p) and divisor (360*p) widths
   localparam int NUM_W = 26;
   localparam int DEN_W = 24;

   localparam int MUL_W  = 18;
   localparam int PROD_W = 2 * MUL_W;

   localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN = -(2 ** (POS_W - 1));

   // quarter-wave polynomial coefficients, q16
   localparam int POLY_A = 102944;
   localparam int POLY_B = 42047;
   localparam int POLY_C = 4640;
   localparam int DEG_TURN = 360;
   localparam int PHASE_BIAS = 720;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd2000;
   localparam logic signed [AMP_W-1:0] AMP_RESET = 9'sd50;

   typedef enum logic [OP_W-1:0] {
      OP_REFRESH   = 3'd0,
      OP_START_NOW = 3'd1,
      OP_START_AT  = 3'd2,
      OP_STOP      = 3'd3,
      OP_REBASE    = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD = 2'd0,
      CSR_AMP    = 2'd1,
      CSR_PHASE  = 2'd2,
      CSR_OFFSET = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] start_time;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    rising;
      logic                    stopped;
      logic [PERIOD_W-1:0]     time_in_period;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP    = 4'd0,
      DP_MOD    = 4'd1,
      DP_PHASE  = 4'd2,
      DP_NUM    = 4'd3,
      DP_DIV    = 4'd4,
      DP_SQ     = 4'd5,
      DP_MULC   = 4'd6,
      DP_MULB   = 4'd7,
      DP_MULA   = 4'd8,
      DP_AMP    = 4'd9,
      DP_FINISH = 4'd10
   } dp_step_type;

   typedef struct packed {
      logic        load;
      dp_step_type step;
      logic        capture;
   } dp_cmd_type;

   typedef struct packed {
      logic go_refresh;
   } dp_status_type;

endpackage

// ===== rtl/svo_dp.sv =====
module svo_dp #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int FRACTION_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  svo_pkg::dp_cmd_type                 cmd,
   output svo_pkg::dp_status_type              status,
   input  svo_pkg::req_type                    req,
   input  logic                                csr_valid,
   input  logic [svo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [svo_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output svo_pkg::rsp_type                    rsp
);
   import svo_pkg::*;

   localparam int TB  = SINE_TABLE_BITS;
   localparam int QW  = TB - 1;
   localparam int XSH = 18 - TB;
   localparam int RSH = 16 - FRACTION_BITS;
   localparam logic [QW-1:0] Q_QUARTER = {1'b1, {(TB - 2){1'b0}}};
   localparam logic signed [PROD_W-1:0] HALF = (36'sd1 <<< RSH) >>> 1;
   localparam logic signed [PROD_W-1:0] POS_HI = 36'(POS_MAX);
   localparam logic signed [PROD_W-1:0] POS_LO = 36'(POS_MIN);

   // configuration
   logic [PERIOD_W-1:0]        period_ff;
   logic signed [AMP_W-1:0]    amp_ff;
   logic signed [PHASE_W-1:0]  phase_ff;
   logic signed [OFFSET_W-1:0] offset_ff;

   // oscillator state
   logic                    running_ff;
   logic [TIME_W-1:0]       ref_ff;
   logic signed [POS_W-1:0] last_ff;
   logic                    dir_ff;
   logic [PERIOD_W-1:0]     pp_ff;

   // working registers
   logic [TIME_W-1:0]       diff_ff;
   logic [PERIOD_W-1:0]     mrem_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DEN_W-1:0]        drem_ff;
   logic [2:0]              dd_ff;
   logic [TB-1:0]           q_ff;
   logic [16:0]             x_ff;
   logic [16:0]             x2_ff;
   logic                    neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   rsp_type                 rsp_ff;

   logic [PERIOD_W-1:0]  p_eff;
   logic [PERIOD_W:0]    mod_r2;
   logic                 mod_ge;
   logic [PERIOD_W-1:0]  mod_next;
   logic [11:0]          phase_ext;
   logic [NUM_W-1:0]     num;
   logic [DEN_W-1:0]     den;
   logic [DEN_W:0]       div_r2;
   logic                 div_ge;
   logic [DEN_W:0]       div_sub;
   logic [1:0]           quad;
   logic [TB-3:0]        rpart;
   logic [QW-1:0]        qv;
   logic [16:0]          x_val;
   logic [16:0]          x2;
   logic [15:0]          tt_b;
   logic [16:0]          tt_a;
   logic [17:0]          t3;
   logic [16:0]          s_mag;
   logic signed [MUL_W-1:0] s_signed;
   logic signed [MUL_W-1:0] mul_a;
   logic signed [MUL_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] pos_w;
   logic signed [POS_W-1:0]  pos_sat;

   assign p_eff    = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign mod_r2   = {mrem_ff, diff_ff[TIME_W-1]};
   assign mod_ge   = mod_r2 >= {1'b0, p_eff};
   assign mod_next = mod_ge ? PERIOD_W'(mod_r2 - {1'b0, p_eff}) : mod_r2[PERIOD_W-1:0];

   // phase + 720 is always positive and fits 11 bits
   assign phase_ext = {{2{phase_ff[PHASE_W-1]}}, phase_ff} + 12'(PHASE_BIAS);
   assign num = NUM_W'({11'b0, mrem_ff} * 26'(DEG_TURN)) + NUM_W'(prod_ff[NUM_W-1:0]);
   assign den = DEN_W'({9'b0, p_eff} * 24'(DEG_TURN));

   assign div_r2  = {drem_ff, dd_ff[2]};
   assign div_ge  = div_r2 >= {1'b0, den_ff};
   assign div_sub = div_r2 - {1'b0, den_ff};

   // quadrant folding of the table index
   assign quad  = q_ff[TB-1:TB-2];
   assign rpart = q_ff[TB-3:0];
   assign qv    = quad[0] ? QW'(Q_QUARTER - {1'b0, rpart}) : {1'b0, rpart};
   assign x_val = 17'(qv) << XSH;

   assign x2    = prod_ff[32:16];
   assign tt_b  = 16'(POLY_B) - {3'b0, prod_ff[28:16]};
   assign tt_a  = 17'(POLY_A) - {1'b0, prod_ff[31:16]};
   assign t3    = prod_ff[33:16];
   assign s_mag = (t3 > 18'd65536) ? 17'h10000 : t3[16:0];
   assign s_signed = neg_ff ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         DP_PHASE: begin
            mul_a = $signed({7'b0, phase_ext[10:0]});
            mul_b = $signed({3'b0, p_eff});
         end
         DP_SQ: begin
            mul_a = $signed({1'b0, x_val});
            mul_b = $signed({1'b0, x_val});
         end
         DP_MULC: begin
            mul_a = $signed(18'(POLY_C));
            mul_b = $signed({1'b0, x2});
         end
         DP_MULB: begin
            mul_a = $signed({2'b0, tt_b});
            mul_b = $signed({1'b0, x2_ff});
         end
         DP_MULA: begin
            mul_a = $signed({1'b0, tt_a});
            mul_b = $signed({1'b0, x_ff});
         end
         DP_AMP: begin
            mul_a = 18'(amp_ff);
            mul_b = s_signed;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // round half up, floor shift, add centre, saturate
   assign pos_w = ((prod_ff + HALF) >>> RSH) + (36'(offset_ff) <<< FRACTION_BITS);

   always_comb begin
      priority if (pos_w > POS_HI) begin
         pos_sat = POS_W'(POS_HI);
      end else if (pos_w < POS_LO) begin
         pos_sat = POS_W'(POS_LO);
      end else begin
         pos_sat = POS_W'(pos_w);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         amp_ff    <= AMP_RESET;
         phase_ff  <= '0;
         offset_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_AMP:    amp_ff    <= csr_wdata[AMP_W-1:0];
            CSR_PHASE:  phase_ff  <= csr_wdata[PHASE_W-1:0];
            CSR_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            default:    period_ff <= period_ff;
         endcase
      end
   end

   // oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         ref_ff     <= '0;
         last_ff    <= '0;
         dir_ff     <= 1'b1;
         pp_ff      <= '0;
      end else begin
         if (cmd.load) begin
            case (req.op)
               OP_START_NOW: begin
                  ref_ff     <= req.now_ms;
                  running_ff <= 1'b1;
               end
               OP_START_AT: begin
                  ref_ff     <= req.start_time;
                  running_ff <= 1'b1;
               end
               OP_STOP:   running_ff <= 1'b0;
               OP_REBASE: ref_ff <= req.now_ms;
               default:   running_ff <= running_ff;
            endcase
         end
         if (cmd.step == DP_FINISH) begin
            pp_ff   <= mrem_ff;
            dir_ff  <= last_ff < pos_sat;
            last_ff <= pos_sat;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff <= req.now_ms - ref_ff;
         mrem_ff <= '0;
      end
      unique case (cmd.step)
         DP_MOD: begin
            mrem_ff <= mod_next;
            diff_ff <= diff_ff << 1;
         end
         DP_NUM: begin
            den_ff  <= den;
            drem_ff <= DEN_W'(num[NUM_W-1:3]);
            dd_ff   <= num[2:0];
            q_ff    <= '0;
         end
         DP_DIV: begin
            drem_ff <= div_ge ? div_sub[DEN_W-1:0] : div_r2[DEN_W-1:0];
            dd_ff   <= dd_ff << 1;
            q_ff    <= {q_ff[TB-2:0], div_ge};
         end
         DP_SQ: begin
            x_ff   <= x_val;
            neg_ff <= quad[1];
         end
         DP_MULC: x2_ff <= x2;
         default: x_ff <= x_ff;
      endcase
      if (cmd.step == DP_PHASE || cmd.step == DP_SQ || cmd.step == DP_MULC ||
          cmd.step == DP_MULB || cmd.step == DP_MULA || cmd.step == DP_AMP) begin
         prod_ff <= mul_p;
      end
      if (cmd.capture) begin
         rsp_ff.position       <= last_ff;
         rsp_ff.rising         <= dir_ff;
         rsp_ff.stopped        <= ~running_ff;
         rsp_ff.time_in_period <= pp_ff;
      end
   end

   assign status.go_refresh = (req.op == OP_REFRESH) && running_ff;
   assign rsp = rsp_ff;

endmodule

// ===== rtl/svo_ctrl.sv =====
module svo_ctrl #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  svo_pkg::dp_status_type status,
   output svo_pkg::dp_cmd_type    cmd
);
   import svo_pkg::*;

   localparam int MOD_STEPS = TIME_W;
   localparam int DIV_STEPS = SINE_TABLE_BITS + 3;
   localparam int CNT_W = $clog2((MOD_STEPS > DIV_STEPS) ? MOD_STEPS : DIV_STEPS);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_MOD    = 12'b0000_0000_0010,
      S_PHASE  = 12'b0000_0000_0100,
      S_NUM    = 12'b0000_0000_1000,
      S_DIV    = 12'b0000_0001_0000,
      S_SQ     = 12'b0000_0010_0000,
      S_MULC   = 12'b0000_0100_0000,
      S_MULB   = 12'b0000_1000_0000,
      S_MULA   = 12'b0001_0000_0000,
      S_AMP    = 12'b0010_0000_0000,
      S_FINISH = 12'b0100_0000_0000,
      S_WAIT   = 12'b1000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd.load    = 1'b0;
      cmd.step    = DP_NOP;
      cmd.capture = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = status.go_refresh ? S_MOD : S_WAIT;
            end
         end
         S_MOD: begin
            cmd.step = DP_MOD;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MOD_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_PHASE;
            end
         end
         S_PHASE: begin
            cmd.step = DP_PHASE;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.step = DP_NUM;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = DP_DIV;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.step = DP_SQ;
            state_in = S_MULC;
         end
         S_MULC: begin
            cmd.step = DP_MULC;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.step = DP_MULB;
            state_in = S_MULA;
         end
         S_MULA: begin
            cmd.step = DP_MULA;
            state_in = S_AMP;
         end
         S_AMP: begin
            cmd.step = DP_AMP;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.step = DP_FINISH;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (slot_free) begin
               cmd.capture = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/servo_sine_oscillator.sv =====
// channel   direction  handshake              word
// req       in         req_valid / req_ready  op, now_ms, start_time
// rsp       out        rsp_valid / rsp_ready  position, rising, stopped, time_in_period
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata (always ready)
//
// a running refresh goes from accept to result register through the bit-serial period
// modulo, the phase and numerator steps, the bit-serial table index divide, and the
// square, three polynomial, amplitude and finish steps, six of them on one shared 18x18
// multiplier; the capture waits while the previous result is not yet taken
// any other command goes straight to the result wait after accept
// one word in flight; the next word is taken while the previous result still waits
// synchronous active-high reset: stopped, reference 0, position 0, rising 1, registers at reset values
module servo_sine_oscillator #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int FRACTION_BITS   = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // command words
   input  logic                           req_valid,
   output logic                           req_ready,
   input  svo_pkg::req_type               req,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output svo_pkg::rsp_type               rsp,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [svo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svo_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import svo_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: handshakes and step order
   svo_ctrl #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: modulo, index divide, polynomial sine, scaling, state
   svo_dp #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

endmodule

// ===== tb/sv/tb_servo_sine_oscillator.sv =====
module tb_servo_sine_oscillator;
   timeunit 1ns;
   timeprecision 1ps;

   import svo_pkg::*;

   localparam int TABLE_BITS   = 10;
   localparam int FRAC_BITS    = 8;
   // long enough to cover any word in flight, a running refresh included
   localparam int DRAIN_CYCLES = 80;
   localparam int PRINT_CAP    = 100;
   localparam int SCALE_SHIFT  = 16 - FRAC_BITS;

   // command codes the block has no meaning for
   localparam logic [OP_W-1:0] OP_SPARE_LO = OP_REBASE + 1'b1;
   localparam logic [OP_W-1:0] OP_SPARE_HI = {OP_W{1'b1}};

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp;
   logic          csr_valid;
   logic          csr_ready;
   csr_idx_type   csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // percentages of cycles in which the sender idles and the receiver stalls
   int gap_pct   = 0;
   int stall_pct = 0;

   // oscillator state as the block should hold it
   logic                      osc_running = 1'b0;
   logic [TIME_W-1:0]         base_ms     = '0;
   logic signed [POS_W-1:0]   last_pos    = '0;
   logic                      rising_q    = 1'b1;
   logic [PERIOD_W-1:0]       period_pos  = '0;

   // register copies, reset values
   logic [PERIOD_W-1:0]       period_q = PERIOD_RESET;
   logic signed [AMP_W-1:0]   amp_q    = AMP_RESET;
   logic signed [PHASE_W-1:0] phase_q  = '0;
   logic signed [OFFSET_W-1:0] offs_q  = '0;

   // result words still to come back, oldest first
   rsp_type due_words[$];

   logic [TIME_W-1:0] ms_clock = '0;

   int words_sent    = 0;
   int words_checked = 0;
   int reg_writes    = 0;
   int refreshes     = 0;
   int mismatches    = 0;

   servo_sine_oscillator #(
      .SINE_TABLE_BITS(TABLE_BITS),
      .FRACTION_BITS  (FRAC_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // q16 sine of a full-turn table index, quarter wave by polynomial, the rest by symmetry
   function automatic longint wave_q16(longint idx);
      longint quarter, quad, r, q, x, x2, acc;
      quarter = longint'(1) << (TABLE_BITS - 2);
      quad = (idx >> (TABLE_BITS - 2)) & 3;
      r = idx & (quarter - 1);
      q = quad[0] ? (quarter - r) : r;
      x = q << (18 - TABLE_BITS);
      x2 = (x * x) >> 16;
      acc = (POLY_C * x2) >> 16;
      acc = POLY_B - acc;
      acc = (acc * x2) >> 16;
      acc = POLY_A - acc;
      acc = (acc * x) >> 16;
      if (acc > 65536)
         acc = 65536;
      return quad[1] ? -acc : acc;
   endfunction

   // apply one command to the state copy and give the word it should produce
   function automatic rsp_type advance_oscillator(req_type w);
      rsp_type res;
      logic [TIME_W-1:0] p, t;
      longint num, den, idx, v, pos;
      case (w.op)
         OP_REFRESH: begin
            if (osc_running) begin
               // a zero period behaves as one millisecond
               p = (period_q == '0) ? 32'd1 : 32'(period_q);
               t = (w.now_ms - base_ms) % p;
               // bias of two turns keeps the numerator positive for any phase
               num = longint'(t) * DEG_TURN + longint'(int'(phase_q) + PHASE_BIAS) * longint'(p);
               den = longint'(DEG_TURN) * longint'(p);
               idx = ((num << TABLE_BITS) / den) & ((longint'(1) << TABLE_BITS) - 1);
               v = longint'(amp_q) * wave_q16(idx);
               // round half up, then floor
               if (SCALE_SHIFT > 0)
                  v += longint'(1) << (SCALE_SHIFT - 1);
               pos = (v >>> SCALE_SHIFT) + longint'(offs_q) * (longint'(1) << FRAC_BITS);
               if (pos > POS_MAX)
                  pos = POS_MAX;
               if (pos < POS_MIN)
                  pos = POS_MIN;
               period_pos = t[PERIOD_W-1:0];
               rising_q = longint'(last_pos) < pos;
               last_pos = pos[POS_W-1:0];
               refreshes++;
            end
         end
         OP_START_NOW: begin
            base_ms = w.now_ms;
            osc_running = 1'b1;
         end
         OP_START_AT: begin
            base_ms = w.start_time;
            osc_running = 1'b1;
         end
         OP_STOP: osc_running = 1'b0;
         // rebase leaves the running flag alone
         OP_REBASE: base_ms = w.now_ms;
         default: ;
      endcase
      res.position = last_pos;
      res.rising = rising_q;
      res.stopped = !osc_running;
      res.time_in_period = period_pos;
      return res;
   endfunction

   function automatic void apply_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PERIOD: period_q = data[PERIOD_W-1:0];
         CSR_AMP:    amp_q    = data[AMP_W-1:0];
         CSR_PHASE:  phase_q  = data[PHASE_W-1:0];
         CSR_OFFSET: offs_q   = data[OFFSET_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s wrong, got %0d, wanted %0d", $time, what, got, want);
   endtask

   // one command word; valid stays up until the word is taken
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic [TIME_W-1:0] st);
      req_type w;
      w.op = op;
      w.now_ms = now;
      w.start_time = st;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req <= w;
      do @(posedge clock); while (!req_ready);
      due_words.push_back(advance_oscillator(w));
      words_sent++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, let every owed word come back and the datapath settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // registers change only with the block idle
   task automatic load_settings(input logic [CSR_DATA_W-1:0] per,
                                input logic [CSR_DATA_W-1:0] amp,
                                input logic [CSR_DATA_W-1:0] ph,
                                input logic [CSR_DATA_W-1:0] offs);
      wait_idle();
      write_reg(CSR_PERIOD, per);
      write_reg(CSR_AMP, amp);
      write_reg(CSR_PHASE, ph);
      write_reg(CSR_OFFSET, offs);
   endtask

   // straight after reset: stopped, values held, spare codes ignored
   task automatic test_held_after_reset();
      send_cmd(OP_REFRESH, $urandom, $urandom);
      send_cmd(OP_SPARE_LO, 32'd10, 32'd0);
      send_cmd(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(OP_STOP, 32'd11, 32'd0);
   endtask

   // every command, period edges and time wrap at the reset settings
   task automatic test_commands();
      send_cmd(OP_START_NOW, 32'd0, 32'd0);
      send_cmd(OP_REFRESH, 32'd0, 32'd0);
      send_cmd(OP_REFRESH, 32'd1999, 32'd0);
      send_cmd(OP_REFRESH, 32'd2000, 32'd0);
      // now behind the reference, difference wraps
      send_cmd(OP_REFRESH, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OP_START_AT, 32'd5, 32'hFFFF_FFFF);
      send_cmd(OP_REFRESH, 32'd0, 32'd0);
      send_cmd(OP_REBASE, 32'd7, 32'hFFFF_FFFF);
      send_cmd(OP_REFRESH, 32'd8, 32'd0);
      send_cmd(OP_STOP, 32'd9, 32'd0);
      // held while stopped
      send_cmd(OP_REFRESH, 32'd9000, 32'd0);
      send_cmd(OP_REBASE, 32'd100, 32'd0);
   endtask

   // register extremes, zero period and the full signed ranges
   task automatic test_register_extremes();
      load_settings(15'd0, 15'(255), 15'(511), 15'(255));
      send_cmd(OP_START_NOW, 32'd12345, 32'd0);
      send_cmd(OP_REFRESH, 32'd20000, 32'd0);
      send_cmd(OP_REFRESH, 32'hFFFF_FFFF, 32'd0);
      load_settings(15'h7FFF, 15'(-256), 15'(-512), 15'(-256));
      send_cmd(OP_START_AT, 32'd0, 32'h8000_0000);
      send_cmd(OP_REFRESH, 32'h8000_0000 + 32'd16383, 32'd0);
      send_cmd(OP_REFRESH, 32'h7FFF_FFFF, 32'd0);
   endtask

   // mostly start then a run of refreshes on an advancing clock, with the odd
   // stop, rebase, restart, time jump and spare code thrown in
   task automatic run_random(input int count, input int gap, input int stall);
      int pick, sel;
      logic [OP_W-1:0] op;
      logic [TIME_W-1:0] st;
      logic [CSR_DATA_W-1:0] per;
      sel = $urandom_range(9);
      if (sel < 6)
         per = CSR_DATA_W'($urandom_range(1, 3000));
      else if (sel == 6)
         per = '0;
      else if (sel == 7)
         per = '1;
      else
         per = CSR_DATA_W'($urandom);
      load_settings(per, CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      gap_pct = gap;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 70)
            ms_clock += $urandom_range(1, 3);
         else if (sel < 90)
            ms_clock += $urandom_range(0, 70000);
         else
            ms_clock = $urandom;
         st = $urandom_range(1) ? ms_clock - $urandom_range(0, 70000) : $urandom;
         pick = $urandom_range(99);
         if (!osc_running) begin
            if (pick < 45)
               op = OP_START_NOW;
            else if (pick < 85)
               op = OP_START_AT;
            else if (pick < 93)
               op = OP_REFRESH;
            else if (pick < 96)
               op = OP_REBASE;
            else
               op = OP_SPARE_LO + OP_W'($urandom_range(0, 2));
         end else begin
            if (pick < 80)
               op = OP_REFRESH;
            else if (pick < 85)
               op = OP_STOP;
            else if (pick < 90)
               op = OP_REBASE;
            else if (pick < 94)
               op = OP_START_AT;
            else if (pick < 97)
               op = OP_START_NOW;
            else
               op = OP_SPARE_LO + OP_W'($urandom_range(0, 2));
         end
         send_cmd(op, ms_clock, st);
      end
   endtask

   // receiver stalls, redrawn each cycle
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // every result word against the oldest one owed
   always @(posedge clock) begin : check_words
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (due_words.size() == 0) begin
            flag_mismatch("word with nothing owed, position", longint'(rsp.position), 0);
         end else begin
            due = due_words.pop_front();
            if (rsp.position !== due.position)
               flag_mismatch("position", longint'(rsp.position), longint'(due.position));
            if (rsp.rising !== due.rising)
               flag_mismatch("rising", longint'(rsp.rising), longint'(due.rising));
            if (rsp.stopped !== due.stopped)
               flag_mismatch("stopped", longint'(rsp.stopped), longint'(due.stopped));
            if (rsp.time_in_period !== due.time_in_period)
               flag_mismatch("time_in_period", longint'(rsp.time_in_period),
                             longint'(due.time_in_period));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PERIOD;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_held_after_reset();
      test_commands();
      test_register_extremes();
      // idling phases: none, sender gaps, receiver stalls, both
      run_random(310, 0, 0);
      run_random(310, 72, 0);
      run_random(310, 0, 72);
      run_random(310, 24, 24);

      wait_idle();
      $display("%0d command words sent, %0d result words checked, %0d of them running refreshes",
               words_sent, words_checked, refreshes);
      $display("%0d register writes across reset, extreme and random settings", reg_writes);
      if (mismatches == 0 && due_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("run stalled with %0d result words still owed", due_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/svo_pkg.sv
rtl/svo_dp.sv
rtl/svo_ctrl.sv
rtl/servo_sine_oscillator.sv
tb/sv/tb_servo_sine_oscillator.sv
